// File: hdl/mf7_pkg.sv
package mf7_pkg;

  // Default bounds of the frame size
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Register values after reset
  localparam int RESET_WIDTH  = 2048;
  localparam int RESET_HEIGHT = 1080;

  // Window geometry
  localparam int WIN_HALF    = 3;
  localparam int WIN_SIZE    = 7;
  localparam int WIN_TAPS    = 49;
  localparam int MEDIAN_RANK = 24;

  // Line memory holds eight row slots, picked by the low row bits
  localparam int SLOT_W    = 3;
  localparam int ROW_SLOTS = 8;

  localparam int PIX_W      = 24;
  localparam int CFG_DATA_W = 13;
  localparam int QUEUE_DEPTH = 4;

  // Register indexes
  localparam logic [0:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;
  } pix_t;

  typedef struct packed {
    logic [7:0]  med_red;
    logic [7:0]  med_green;
    logic [7:0]  med_blue;
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic        burst_last;
    logic        frame_end;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Frame dimension minus one, with zero counted as one and saturation at the bound
  function automatic int dim_m1(int v, int maxv);
    if (v < 1) return 0;
    if (v > maxv) return maxv - 1;
    return v - 1;
  endfunction

endpackage

// File: hdl/mf7_queue.sv
module mf7_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = mf7_pkg::QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output mf7_pkg::q_status_t status
);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    fill;

  assign pop_data     = slots[rd_ptr];
  assign status.full  = (fill == (PTR_W+1)'(DEPTH));
  assign status.empty = (fill == '0);

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: hdl/mf7_front.sv
module mf7_front #(
  parameter int MAX_WIDTH  = mf7_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf7_pkg::DEF_MAX_HEIGHT,
  localparam int CW     = $clog2(MAX_WIDTH),
  localparam int RW     = $clog2(MAX_HEIGHT),
  localparam int AW     = mf7_pkg::SLOT_W + CW,
  localparam int DESC_W = 2 * RW + 2 * CW + 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [mf7_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              pix_valid,
  output logic                              pix_ready,
  input  mf7_pkg::pix_t                     pix,
  input  mf7_pkg::q_status_t                q_status,
  input  logic                              back_idle,
  output logic                              push,
  output logic [DESC_W-1:0]                 push_data,
  output logic                              wr_en,
  output logic [AW-1:0]                     wr_addr,
  output logic [mf7_pkg::PIX_W-1:0]         wr_data,
  output logic [CW-1:0]                     width_m1,
  output logic [RW-1:0]                     height_m1
);

  typedef struct packed {
    logic [RW-1:0] rlo;
    logic [RW-1:0] rhi;
    logic [CW-1:0] clo;
    logic [CW-1:0] chi;
    logic          last_pixel;
  } desc_t;

  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count;
  logic          accept;
  logic          row_end;
  logic          col_end;
  logic          row_ge;
  logic          col_ge;
  desc_t         desc;

  // Hold off the first word of a row until all earlier work has drained
  assign pix_ready = !q_status.full &&
                     ((col_count != '0) || (q_status.empty && back_idle));
  assign accept    = pix_valid && pix_ready;

  // Classify the pixel: which window centers it completes
  always_comb begin
    row_end = (row_count == height_m1);
    col_end = (col_count == width_m1);
    row_ge  = (row_count >= RW'(mf7_pkg::WIN_HALF));
    col_ge  = (col_count >= CW'(mf7_pkg::WIN_HALF));
    desc.rlo = row_ge ? row_count - RW'(mf7_pkg::WIN_HALF) : '0;
    desc.rhi = row_end ? row_count : row_count - RW'(mf7_pkg::WIN_HALF);
    desc.clo = col_ge ? col_count - CW'(mf7_pkg::WIN_HALF) : '0;
    desc.chi = col_end ? col_count : col_count - CW'(mf7_pkg::WIN_HALF);
    desc.last_pixel = row_end && col_end;
  end

  assign push      = accept && (row_end || row_ge) && (col_end || col_ge);
  assign push_data = desc;

  // Write the pixel into its row slot
  assign wr_en   = accept;
  assign wr_addr = {row_count[mf7_pkg::SLOT_W-1:0], col_count};
  assign wr_data = pix;

  // Frame size registers and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      width_m1  <= CW'(mf7_pkg::dim_m1(mf7_pkg::RESET_WIDTH, MAX_WIDTH));
      height_m1 <= RW'(mf7_pkg::dim_m1(mf7_pkg::RESET_HEIGHT, MAX_HEIGHT));
      row_count <= '0;
      col_count <= '0;
    end else if (cfg_we) begin
      if (cfg_index == mf7_pkg::CFG_IMAGE_WIDTH) begin
        width_m1 <= CW'(mf7_pkg::dim_m1(int'(cfg_data[11:0]), MAX_WIDTH));
      end else begin
        height_m1 <= RW'(mf7_pkg::dim_m1(int'(cfg_data[12:0]), MAX_HEIGHT));
      end
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_count <= '0;
        row_count <= row_end ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

endmodule

// File: hdl/mf7_back.sv
module mf7_back #(
  parameter int MAX_WIDTH  = mf7_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf7_pkg::DEF_MAX_HEIGHT,
  localparam int CW     = $clog2(MAX_WIDTH),
  localparam int RW     = $clog2(MAX_HEIGHT),
  localparam int AW     = mf7_pkg::SLOT_W + CW,
  localparam int DESC_W = 2 * RW + 2 * CW + 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [mf7_pkg::PIX_W-1:0] wr_data,
  input  logic [CW-1:0]             width_m1,
  input  logic [RW-1:0]             height_m1,
  input  mf7_pkg::q_status_t        q_status,
  input  logic [DESC_W-1:0]         pop_data,
  output logic                      pop,
  output logic                      idle,
  output logic                      res_valid,
  input  logic                      res_ready,
  output mf7_pkg::res_t             res
);

  localparam int TAPS   = mf7_pkg::WIN_TAPS;
  localparam int DEPTH  = mf7_pkg::ROW_SLOTS << CW;
  localparam int CNT_W  = $clog2(TAPS + 1);

  typedef struct packed {
    logic [RW-1:0] rlo;
    logic [RW-1:0] rhi;
    logic [CW-1:0] clo;
    logic [CW-1:0] chi;
    logic          last_pixel;
  } desc_t;

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_DRAIN, S_SEL, S_EMIT} state_t;

  state_t                    state;
  desc_t                     desc;
  logic [RW-1:0]             r0;
  logic [CW-1:0]             c0;
  logic [2:0]                dr;
  logic [2:0]                dc;
  logic [2:0]                bit_idx;
  logic                      rd_en;
  logic                      rd_valid;
  logic [AW-1:0]             rd_addr;
  logic [mf7_pkg::PIX_W-1:0] mem_q;
  logic [mf7_pkg::PIX_W-1:0] line_mem [DEPTH];
  logic [mf7_pkg::PIX_W-1:0] vals [TAPS];
  logic [TAPS-1:0]           mask  [3];
  logic [TAPS-1:0]           plane [3];
  logic [TAPS-1:0]           zeros [3];
  logic [CNT_W-1:0]          cnt0  [3];
  logic [CNT_W-1:0]          rank  [3];
  logic [7:0]                med   [3];
  logic signed [RW+1:0]      rsum;
  logic signed [CW+1:0]      csum;
  logic [RW-1:0]             k_row;
  logic [CW-1:0]             k_col;
  logic                      out_last;
  logic                      emit_ok;

  function automatic logic [CNT_W-1:0] count_ones(logic [TAPS-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < TAPS; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

  assign idle     = (state == S_IDLE);
  assign pop      = (state == S_IDLE) && !q_status.empty;
  assign rd_en    = (state == S_FETCH);
  assign out_last = (r0 == desc.rhi) && (c0 == desc.chi);
  assign emit_ok  = !res_valid || res_ready;

  // Clamp the tap position to the frame
  always_comb begin
    rsum = $signed({2'b00, r0}) + $signed((RW+2)'(dr)) - (RW+2)'(mf7_pkg::WIN_HALF);
    csum = $signed({2'b00, c0}) + $signed((CW+2)'(dc)) - (CW+2)'(mf7_pkg::WIN_HALF);
    if (rsum < 0) begin
      k_row = '0;
    end else if (rsum > $signed({2'b00, height_m1})) begin
      k_row = height_m1;
    end else begin
      k_row = rsum[RW-1:0];
    end
    if (csum < 0) begin
      k_col = '0;
    end else if (csum > $signed({2'b00, width_m1})) begin
      k_col = width_m1;
    end else begin
      k_col = csum[CW-1:0];
    end
  end

  assign rd_addr = {k_row[mf7_pkg::SLOT_W-1:0], k_col};

  // Line memory: one write port from the front, one read port here
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= line_mem[rd_addr];
    end
  end

  // Bit planes of the window for the bit under test; channel 0 is blue
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < TAPS; i++) begin
        plane[ch][i] = vals[i][ch * 8 + int'(bit_idx)];
      end
      zeros[ch] = mask[ch] & ~plane[ch];
      cnt0[ch]  = count_ones(zeros[ch]);
    end
  end

  // Shift fetched taps into the window
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        vals[i] <= vals[i + 1];
      end
      vals[TAPS-1] <= mem_q;
    end
  end

  // Sequencer: fetch 49 taps, select the median bit by bit, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_valid  <= 1'b0;
      res_valid <= 1'b0;
      dr        <= '0;
      dc        <= '0;
      bit_idx   <= '0;
    end else begin
      rd_valid <= rd_en;
      if (res_valid && res_ready && (state != S_EMIT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_status.empty) begin
            desc  <= pop_data;
            r0    <= pop_data[DESC_W-1 -: RW];
            c0    <= pop_data[2*CW : CW+1];
            dr    <= '0;
            dc    <= '0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (dc == 3'(mf7_pkg::WIN_SIZE - 1)) begin
            dc <= '0;
            if (dr == 3'(mf7_pkg::WIN_SIZE - 1)) begin
              dr    <= '0;
              state <= S_DRAIN;
            end else begin
              dr <= dr + 1'b1;
            end
          end else begin
            dc <= dc + 1'b1;
          end
        end
        S_DRAIN: begin
          for (int ch = 0; ch < 3; ch++) begin
            mask[ch] <= '1;
            rank[ch] <= CNT_W'(mf7_pkg::MEDIAN_RANK);
          end
          bit_idx <= 3'd7;
          state   <= S_SEL;
        end
        S_SEL: begin
          for (int ch = 0; ch < 3; ch++) begin
            if (rank[ch] < cnt0[ch]) begin
              mask[ch]         <= zeros[ch];
              med[ch][bit_idx] <= 1'b0;
            end else begin
              mask[ch]         <= mask[ch] & plane[ch];
              rank[ch]         <= rank[ch] - cnt0[ch];
              med[ch][bit_idx] <= 1'b1;
            end
          end
          if (bit_idx == '0) begin
            state <= S_EMIT;
          end else begin
            bit_idx <= bit_idx - 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            res.med_red    <= med[2];
            res.med_green  <= med[1];
            res.med_blue   <= med[0];
            res.out_row    <= 12'(r0);
            res.out_col    <= 11'(c0);
            res.burst_last <= out_last;
            res.frame_end  <= out_last && desc.last_pixel;
            res_valid      <= 1'b1;
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              if (c0 == desc.chi) begin
                c0 <= desc.clo;
                r0 <= r0 + 1'b1;
              end else begin
                c0 <= c0 + 1'b1;
              end
              state <= S_FETCH;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/median_filter_7x7_rgb.sv
// 7x7 per-channel median filter over an RGB frame streamed in raster order.
// Pixel words enter on pix_valid/pix_ready; result words leave on
// res_valid/res_ready. Each result carries the three medians, its row and
// column, burst_last on the final result released by one pixel, and frame_end
// on the final result of the frame. Frame edges replicate the border pixel.
// image_width (index 0) and image_height (index 1) are written via cfg_we;
// a write restarts the frame at row 0, column 0.
// A pixel is accepted while the job queue (four entries) has room;
// the first pixel of each row waits until all earlier jobs have finished.
// The back end works on one result at a time: 49 reads of the single read
// port of the line memory, a drain state, eight bit-serial selection steps
// and a load of the output register, after an idle state for the first of a burst.
// Reset clears the position counters, the queue and res_valid and
// loads width 2048 and height 1080; the line memory is not cleared.
// While the receiver stalls, the output register holds its word; the back
// end finishes the next result and waits, and the queue then fills and
// lowers pix_ready.
module median_filter_7x7_rgb #(
  parameter int MAX_WIDTH  = mf7_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf7_pkg::DEF_MAX_HEIGHT,
  localparam int CW     = $clog2(MAX_WIDTH),
  localparam int RW     = $clog2(MAX_HEIGHT),
  localparam int AW     = mf7_pkg::SLOT_W + CW,
  localparam int DESC_W = 2 * RW + 2 * CW + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [mf7_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           pix_valid,
  output logic                           pix_ready,
  input  mf7_pkg::pix_t                  pix,
  output logic                           res_valid,
  input  logic                           res_ready,
  output mf7_pkg::res_t                  res
);

  mf7_pkg::q_status_t        q_status;
  logic                      push;
  logic [DESC_W-1:0]         push_data;
  logic                      pop;
  logic [DESC_W-1:0]         pop_data;
  logic                      back_idle;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [mf7_pkg::PIX_W-1:0] wr_data;
  logic [CW-1:0]             width_m1;
  logic [RW-1:0]             height_m1;

  mf7_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .q_status  (q_status),
    .back_idle (back_idle),
    .push      (push),
    .push_data (push_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .width_m1  (width_m1),
    .height_m1 (height_m1)
  );

  mf7_queue #(
    .DATA_W (DESC_W),
    .DEPTH  (mf7_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  mf7_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .width_m1  (width_m1),
    .height_m1 (height_m1),
    .q_status  (q_status),
    .pop_data  (pop_data),
    .pop       (pop),
    .idle      (back_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Never push a job into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("job pushed into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("job popped from empty queue");

  // The frame's final result also closes its burst
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_end |-> res.burst_last)
    else $error("frame_end without burst_last");

  // A popped job starts work in the next cycle
  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    pop |=> !back_idle)
    else $error("back end stayed idle after pop");

endmodule

// File: test/testbench.sv
module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = mf7_pkg::CFG_IMAGE_WIDTH;
  logic [mf7_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic pix_valid = 1'b0;
  logic pix_ready;
  mf7_pkg::pix_t pix = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  mf7_pkg::res_t res;

  median_filter_7x7_rgb u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  always #5 clk = ~clk;

  // Predictor state: raw register values, frame position and pixels of this frame
  int   width_reg = mf7_pkg::RESET_WIDTH;
  int   height_reg = mf7_pkg::RESET_HEIGHT;
  int   next_row = 0;
  int   next_col = 0;
  mf7_pkg::pix_t frame_pix [int];
  mf7_pkg::res_t median_q [$];
  int   errors = 0;
  int   words_in = 0;
  int   words_out = 0;
  int   frames_done = 0;
  bit   steady_rx = 1'b0;

  function automatic int clamp_dim(int v, int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int clip(int x, int hi);
    if (x < 0) return 0;
    if (x > hi) return hi;
    return x;
  endfunction

  // Work out the medians released by one accepted pixel word
  function automatic void predict_medians(mf7_pkg::pix_t p);
    int w, h, rlo, rhi, clo, chi, n, half, upper;
    bit have_r, have_c, last_px;
    int hr [256], hg [256], hb [256];
    int ar, ag, ab;
    mf7_pkg::pix_t q;
    mf7_pkg::res_t o;
    half = mf7_pkg::WIN_HALF;
    upper = mf7_pkg::WIN_TAPS - mf7_pkg::MEDIAN_RANK;
    w = clamp_dim(width_reg, mf7_pkg::DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, mf7_pkg::DEF_MAX_HEIGHT);
    frame_pix[next_row * 8192 + next_col] = p;
    last_px = (next_row == h - 1) && (next_col == w - 1);
    have_r = 1'b0;
    have_c = 1'b0;
    n = 0;
    if (next_row == h - 1) begin
      rlo = (next_row >= half) ? next_row - half : 0; rhi = next_row; have_r = 1'b1;
    end else if (next_row >= half) begin
      rlo = next_row - half; rhi = rlo; have_r = 1'b1;
    end
    if (next_col == w - 1) begin
      clo = (next_col >= half) ? next_col - half : 0; chi = next_col; have_c = 1'b1;
    end else if (next_col >= half) begin
      clo = next_col - half; chi = clo; have_c = 1'b1;
    end
    if (have_r && have_c) begin
      for (int r0 = rlo; r0 <= rhi; r0++) begin
        for (int c0 = clo; c0 <= chi; c0++) begin
          for (int v = 0; v < 256; v++) begin
            hr[v] = 0; hg[v] = 0; hb[v] = 0;
          end
          for (int dr = -half; dr <= half; dr++) begin
            for (int dc = -half; dc <= half; dc++) begin
              q = frame_pix[clip(r0 + dr, h - 1) * 8192 + clip(c0 + dc, w - 1)];
              hr[q.pix_red]++; hg[q.pix_green]++; hb[q.pix_blue]++;
            end
          end
          // Pick the value of rank 24 from each histogram
          o = '0;
          ar = 0; ag = 0; ab = 0;
          for (int v = 255; v >= 0; v--) begin
            ar += hr[v]; ag += hg[v]; ab += hb[v];
            if (ar >= upper && hr[v] != 0 && ar - hr[v] < upper)
              o.med_red = v[7:0];
            if (ag >= upper && hg[v] != 0 && ag - hg[v] < upper)
              o.med_green = v[7:0];
            if (ab >= upper && hb[v] != 0 && ab - hb[v] < upper)
              o.med_blue = v[7:0];
          end
          o.out_row = r0[11:0];
          o.out_col = c0[10:0];
          median_q.insert(median_q.size(), o);
          n++;
        end
      end
      median_q[median_q.size() - 1].burst_last = 1'b1;
      if (last_px) begin
        median_q[median_q.size() - 1].frame_end = 1'b1;
        frames_done++;
      end
    end
    // Advance the frame position
    if (next_col >= w - 1) begin
      next_col = 0;
      next_row = (next_row >= h - 1) ? 0 : next_row + 1;
      if (next_row == 0) frame_pix.delete();
    end else begin
      next_col++;
    end
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(99);
    if (k < 65) return 0;
    if (k < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Receiver stalls
  int rx_hold = 0;
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (steady_rx) begin
      res_ready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      res_ready <= 1'b0;
    end else begin
      rx_hold <= pick_gap();
      res_ready <= 1'b1;
    end
  end

  // Check each result word against the oldest expected one
  always @(negedge clk) begin
    mf7_pkg::res_t e;
    if (!rst && res_valid && res_ready) begin
      words_out++;
      if (median_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, res);
        errors++;
      end else begin
        e = median_q.pop_front();
        if (res.med_red !== e.med_red) begin
          $display("%0t: med_red expected %0d actual %0d", $time, e.med_red, res.med_red);
          errors++;
        end
        if (res.med_green !== e.med_green) begin
          $display("%0t: med_green expected %0d actual %0d", $time, e.med_green, res.med_green);
          errors++;
        end
        if (res.med_blue !== e.med_blue) begin
          $display("%0t: med_blue expected %0d actual %0d", $time, e.med_blue, res.med_blue);
          errors++;
        end
        if (res.out_row !== e.out_row) begin
          $display("%0t: out_row expected %0d actual %0d", $time, e.out_row, res.out_row);
          errors++;
        end
        if (res.out_col !== e.out_col) begin
          $display("%0t: out_col expected %0d actual %0d", $time, e.out_col, res.out_col);
          errors++;
        end
        if (res.burst_last !== e.burst_last) begin
          $display("%0t: burst_last expected %0b actual %0b", $time, e.burst_last,
                   res.burst_last);
          errors++;
        end
        if (res.frame_end !== e.frame_end) begin
          $display("%0t: frame_end expected %0b actual %0b", $time, e.frame_end,
                   res.frame_end);
          errors++;
        end
      end
    end
  end

  // Send one pixel word, holding it until accepted
  task automatic send_pix(mf7_pkg::pix_t p);
    int gap;
    bit rdy;
    gap = pick_gap();
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix <= p;
    pix_valid <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pix_ready;
      @(posedge clk);
    end while (!rdy);
    words_in++;
    predict_medians(p);
  endtask

  task automatic drain();
    pix_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, int val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[mf7_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mf7_pkg::CFG_IMAGE_WIDTH) width_reg = val & 'hFFF;
    else height_reg = val & 'h1FFF;
    next_row = 0;
    next_col = 0;
    frame_pix.delete();
  endtask

  function automatic mf7_pkg::pix_t rand_pix();
    return mf7_pkg::pix_t'(24'($urandom_range(24'hFFFFFF)));
  endfunction

  // Extreme channel values in a 4x4 frame
  task automatic test_extremes();
    mf7_pkg::pix_t p;
    write_reg(mf7_pkg::CFG_IMAGE_WIDTH, 4);
    write_reg(mf7_pkg::CFG_IMAGE_HEIGHT, 4);
    for (int i = 0; i < 16; i++) begin
      p.pix_red = (i % 2) ? 8'hFF : 8'h00;
      p.pix_green = (i % 3) ? 8'h00 : 8'hFF;
      p.pix_blue = (i < 8) ? 8'hFF : 8'h00;
      send_pix(p);
    end
  endtask

  // Zero sizes count as one; a 2x3 frame releases everything at its last row
  task automatic test_small_frames();
    write_reg(mf7_pkg::CFG_IMAGE_WIDTH, 0);
    write_reg(mf7_pkg::CFG_IMAGE_HEIGHT, 0);
    send_pix(rand_pix());
    send_pix(rand_pix());
    write_reg(mf7_pkg::CFG_IMAGE_WIDTH, 2);
    write_reg(mf7_pkg::CFG_IMAGE_HEIGHT, 3);
    repeat (6) send_pix(rand_pix());
  endtask

  // Oversized registers saturate; frames are left unfinished
  task automatic test_saturation();
    write_reg(mf7_pkg::CFG_IMAGE_WIDTH, 4095);
    write_reg(mf7_pkg::CFG_IMAGE_HEIGHT, 1);
    repeat (12) send_pix(rand_pix());
    write_reg(mf7_pkg::CFG_IMAGE_WIDTH, 1);
    write_reg(mf7_pkg::CFG_IMAGE_HEIGHT, 8191);
    repeat (10) send_pix(rand_pix());
  endtask

  // Random frames, mostly complete, some cut short by a register write
  task automatic test_random();
    int w, h, npx;
    while (words_in < 410) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(12, 4);
      h = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(10, 4);
      write_reg(mf7_pkg::CFG_IMAGE_WIDTH, w);
      write_reg(mf7_pkg::CFG_IMAGE_HEIGHT, h);
      steady_rx = ($urandom_range(3) == 0);
      repeat ($urandom_range(2, 1)) begin
        npx = ($urandom_range(4) == 0) ? $urandom_range(w * h, 1) : w * h;
        if (npx > 410 - words_in) npx = 410 - words_in;
        for (int i = 0; i < npx; i++) send_pix(rand_pix());
        // Now and then hold off the sender until all results are back
        if ($urandom_range(3) == 0) drain();
      end
    end
    steady_rx = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_small_frames();
    test_saturation();
    test_random();
    drain();
    $display("Sent %0d pixel words and checked %0d median words over %0d full frames,",
             words_in, words_out, frames_done);
    $display("with zero, small, saturated and random frame sizes and random stalls.");
    if (errors == 0 && median_q.size() == 0) begin
      $display("** median_filter_7x7_rgb: PASSED **");
    end else begin
      $display("** median_filter_7x7_rgb: FAILED **");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("Timeout with %0d words outstanding", median_q.size());
    $display("** median_filter_7x7_rgb: FAILED **");
    $finish;
  end

endmodule

// File: files.f
hdl/mf7_pkg.sv
hdl/mf7_queue.sv
hdl/mf7_front.sv
hdl/mf7_back.sv
hdl/median_filter_7x7_rgb.sv
test/testbench.sv
